@@ hdl/fdss_pkg.sv @@
// Package for the four-digit seven-segment scanner.
// Holds command codes, segment encodings and the constant-divisor reciprocals.
// No dependencies.
`default_nettype none

package fdss_pkg;

  // Command codes, carried in tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int unsigned NUM_W   = 16;
  localparam int unsigned POINT_W = 3;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned DIGITS  = 4;
  localparam int unsigned IDX_W   = 2;

  // Reciprocal multipliers: floor(n / 10^k) == (n * MUL) >> SHIFT for 16-bit n
  localparam int unsigned PROD_W      = 33;
  localparam logic [16:0] DIV10_MUL    = 17'd52429;
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam logic [16:0] DIV1000_MUL  = 17'd67109;
  localparam logic [16:0] DIV10000_MUL = 17'd107375;

  // Quotient widths
  localparam int unsigned Q1_W = 13;  // up to 6553
  localparam int unsigned Q2_W = 10;  // up to 655
  localparam int unsigned Q3_W = 7;   // up to 65
  localparam int unsigned Q4_W = 3;   // up to 6

  // Pin layout: bit 0..6 = A..G, bit 7 = DP
  localparam logic [SEG_W-1:0] DP_BIT = 8'h80;
  localparam logic [SEG_W-1:0] BLANK  = 8'h00;

  // Decimal digit to segment pins
  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
    logic [SEG_W-1:0] pins;
    case (digit)
      4'd0:    pins = 8'h3F;
      4'd1:    pins = 8'h06;
      4'd2:    pins = 8'h5B;
      4'd3:    pins = 8'h4F;
      4'd4:    pins = 8'h66;
      4'd5:    pins = 8'h6D;
      4'd6:    pins = 8'h7D;
      4'd7:    pins = 8'h07;
      4'd8:    pins = 8'h7F;
      4'd9:    pins = 8'h6F;
      default: pins = BLANK;
    endcase
    return pins;
  endfunction

endpackage

`default_nettype wire

@@ hdl/four_digit_seven_segment_scanner.sv @@
// Four-digit multiplexed seven-segment scanner, top level.
// Depends on fdss_pkg.
`default_nettype none

// Usage: every input transaction yields exactly one output transaction. A load
// (tuser = 0) splits tdata's number into four decimal digits, blanks leading
// zeros (digit 0 always shows), adds the decimal point when point_position is
// below 4, and stores the patterns; its result repeats the pins currently
// driven. A tick (tuser = 1) drives the pattern and active-low select of the
// digit under the scan index and advances the scan. The four parallel
// reciprocal multiplies that split the number feed the stage 1 registers;
// digit recovery, encoding and the pin registers form stage 2. One
// transaction per cycle is accepted when the output side keeps up. After
// reset the pins are blank and no digit is selected.

module four_digit_seven_segment_scanner (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [15:0] number, [18:16] point_position, rest 0
  input  wire logic        s_axis_tuser,  // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [7:0] segment_drive, [11:8] digit_select_n, rest 0
);

  // Stage 1: registered input plus quotients
  logic                                 s1_vld_q;
  logic                                 s1_cmd_q;
  logic [fdss_pkg::NUM_W-1:0]           s1_num_q;
  logic [fdss_pkg::POINT_W-1:0]         s1_pt_q;
  logic [fdss_pkg::Q1_W-1:0]            s1_q1_q;
  logic [fdss_pkg::Q2_W-1:0]            s1_q2_q;
  logic [fdss_pkg::Q3_W-1:0]            s1_q3_q;
  logic [fdss_pkg::Q4_W-1:0]            s1_q4_q;

  // Stage 2 state and result register
  logic [fdss_pkg::SEG_W-1:0]           pat_q [fdss_pkg::DIGITS];
  logic [fdss_pkg::IDX_W-1:0]           scan_q;
  logic [fdss_pkg::SEG_W-1:0]           seg_q, seg_d;
  logic [fdss_pkg::DIGITS-1:0]          sel_q, sel_d;
  logic                                 out_vld_q;

  logic                                 in_acc;
  logic                                 adv2;
  logic [fdss_pkg::NUM_W-1:0]           in_num;
  logic [fdss_pkg::PROD_W-1:0]          p10, p100, p1000, p10000;
  logic [3:0]                           dig [fdss_pkg::DIGITS];
  logic [fdss_pkg::NUM_W-1:0]           rem0;
  logic [fdss_pkg::Q1_W-1:0]            rem1;
  logic [fdss_pkg::Q2_W-1:0]            rem2;
  logic [fdss_pkg::Q3_W-1:0]            rem3;
  logic [fdss_pkg::DIGITS-1:0]          blank;
  logic [fdss_pkg::SEG_W-1:0]           new_pat [fdss_pkg::DIGITS];

  // Handshake: stage 2 moves when the result register is free or being taken
  assign adv2          = s1_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !s1_vld_q || adv2;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Reciprocal multiplies, one per power of ten, all in parallel
  assign in_num = s_axis_tdata[15:0];
  assign p10    = fdss_pkg::PROD_W'(in_num) * fdss_pkg::PROD_W'(fdss_pkg::DIV10_MUL);
  assign p100   = fdss_pkg::PROD_W'(in_num) * fdss_pkg::PROD_W'(fdss_pkg::DIV100_MUL);
  assign p1000  = fdss_pkg::PROD_W'(in_num) * fdss_pkg::PROD_W'(fdss_pkg::DIV1000_MUL);
  assign p10000 = fdss_pkg::PROD_W'(in_num) * fdss_pkg::PROD_W'(fdss_pkg::DIV10000_MUL);

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q <= s_axis_tuser;
      s1_num_q <= in_num;
      s1_pt_q  <= s_axis_tdata[18:16];
      s1_q1_q  <= p10[31:19];
      s1_q2_q  <= p100[32:23];
      s1_q3_q  <= p1000[32:26];
      s1_q4_q  <= p10000[32:30];
    end
  end

  // Digit recovery: d_k = q_k - 10 * q_(k+1)
  always_comb begin
    rem0   = s1_num_q - fdss_pkg::NUM_W'(s1_q1_q) * fdss_pkg::NUM_W'(10);
    rem1   = s1_q1_q - fdss_pkg::Q1_W'(s1_q2_q) * fdss_pkg::Q1_W'(10);
    rem2   = s1_q2_q - fdss_pkg::Q2_W'(s1_q3_q) * fdss_pkg::Q2_W'(10);
    rem3   = s1_q3_q - fdss_pkg::Q3_W'(s1_q4_q) * fdss_pkg::Q3_W'(10);
    dig[0] = rem0[3:0];
    dig[1] = rem1[3:0];
    dig[2] = rem2[3:0];
    dig[3] = rem3[3:0];
    // leading zero: number below 10^k means quotient k is zero
    blank  = {s1_q3_q == '0, s1_q2_q == '0, s1_q1_q == '0, 1'b0};
  end

  // New patterns with blanking and decimal point
  always_comb begin
    for (int k = 0; k < fdss_pkg::DIGITS; k++) begin
      new_pat[k] = blank[k] ? fdss_pkg::BLANK : fdss_pkg::seg_encode(dig[k]);
      if (!s1_pt_q[2] && (s1_pt_q[1:0] == fdss_pkg::IDX_W'(k))) begin
        new_pat[k] = new_pat[k] | fdss_pkg::DP_BIT;
      end
    end
  end

  // Pin values for a tick
  always_comb begin
    seg_d = seg_q;
    sel_d = sel_q;
    if (s1_cmd_q == fdss_pkg::CMD_TICK) begin
      seg_d = pat_q[scan_q];
      sel_d = ~(fdss_pkg::DIGITS'(1) << scan_q);
    end
  end

  // Stage 2 registers: patterns, scan index, pins, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < fdss_pkg::DIGITS; k++) begin
        pat_q[k] <= fdss_pkg::BLANK;
      end
      scan_q    <= '0;
      seg_q     <= fdss_pkg::BLANK;
      sel_q     <= '1;
      out_vld_q <= 1'b0;
    end else begin
      if (adv2) begin
        seg_q <= seg_d;
        sel_q <= sel_d;
        if (s1_cmd_q == fdss_pkg::CMD_LOAD) begin
          for (int k = 0; k < fdss_pkg::DIGITS; k++) begin
            pat_q[k] <= new_pat[k];
          end
        end else begin
          scan_q <= scan_q + fdss_pkg::IDX_W'(1);
        end
      end
      if (adv2) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, sel_q, seg_q};

`ifndef SYNTHESIS
  // At most one digit is ever selected
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~sel_q) <= 1)
    else $error("more than one digit selected");

  // A tick selects the digit that was under the scan index and advances it
  a_tick_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 && (s1_cmd_q == fdss_pkg::CMD_TICK) |=>
      (sel_q[$past(scan_q)] == 1'b0) && (scan_q == $past(scan_q) + 2'd1))
    else $error("tick did not drive the scanned digit");

  // A load leaves the pins and the scan index alone
  a_load_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 && (s1_cmd_q == fdss_pkg::CMD_LOAD) |=>
      $stable(seg_q) && $stable(sel_q) && $stable(scan_q))
    else $error("load changed the pins");
`endif

endmodule

`default_nettype wire
